@@ hw/rtl/bsc_pkg.sv @@
package bsc_pkg;

  // Default sizes of the block.
  localparam int DEF_MAX_PROCESSES = 16;
  localparam int DEF_MAX_RESOURCES = 10;
  localparam int DEF_COUNT_WIDTH   = 16;

  // Fixed field widths of the item and configuration channels.
  localparam int REQ_W      = 2;
  localparam int PROC_W     = 4;
  localparam int RES_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int PCNT_W     = 5;
  localparam int RCNT_W     = 4;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOAD_PROC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_AVAIL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN        = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'd1;

endpackage

@@ hw/rtl/bsc_table_mem.sv @@
module bsc_table_mem #(
  parameter int DATA_W = 33,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bankers_safety_check_unit.sv @@
// Banker's algorithm safety checker. Load items write one process/resource
// entry (maximum and allocation, kept as need and allocation in one table
// memory) or one available count. A run item copies the available counts
// into work and then repeats rounds: each round streams the table memory one
// entry per cycle over every unfinished process and every resource in use,
// picks the fitting process with the smallest need of resource 0, emits its
// id, and then reads its allocation row, one entry per cycle, into work. The
// pace of the rounds is set by the one read port of the table memory. The run
// ends with a verdict item marked last; no new item is taken until the run is
// over. Configuration is to be written by the user only while idle; the block
// itself does not enforce it.
module bankers_safety_check_unit
  import bsc_pkg::*;
#(
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // Item input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [REQ_W-1:0]       req_type,
  input  logic [PROC_W-1:0]      proc_index,
  input  logic [RES_W-1:0]       res_index,
  input  logic [COUNT_WIDTH-1:0] max_value,
  input  logic [COUNT_WIDTH-1:0] alloc_value,
  input  logic [COUNT_WIDTH-1:0] avail_value,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PROC_W-1:0]      seq_process,
  output logic                   is_verdict,
  output logic                   safe,
  output logic                   last,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW    = $clog2(MAX_PROCESSES);
  localparam int PCW   = $clog2(MAX_PROCESSES + 1);
  localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int RCW   = $clog2(MAX_RESOURCES + 1);
  localparam int NW    = COUNT_WIDTH + 1;
  localparam int WW    = COUNT_WIDTH + $clog2(MAX_PROCESSES + 1);
  localparam int AW    = PW + RW;
  localparam int MEM_W = NW + COUNT_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_ADD,
    ST_ADD_DRAIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PCNT_W-1:0] process_count;
  logic [RCNT_W-1:0] resource_count;

  // Available and work counts.
  logic [COUNT_WIDTH-1:0] avail [MAX_RESOURCES];
  logic [WW-1:0]          work  [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] finished;

  // Sequencer registers.
  logic [PCW-1:0]       ip;
  logic [RW-1:0]        ir;
  logic [PCW-1:0]       done_count;
  logic                 found;
  logic [PW-1:0]        pick;
  logic signed [NW-1:0] best_need;
  logic signed [NW-1:0] need0;
  logic                 fit_acc;

  // Tags that travel alongside the memory read.
  logic          sv;
  logic [PW-1:0] s_p;
  logic [RW-1:0] s_r;
  logic          s_first;
  logic          s_last;
  logic          av;
  logic [RW-1:0] a_r;

  // Table memory ports.
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [MEM_W-1:0] mem_rdata;

  logic [PCW-1:0]        np;
  logic [RCW-1:0]        nr;
  logic [RW-1:0]         nr_last;
  logic [PW-1:0]         ip_idx;
  logic                  in_acc;
  logic                  proc_ok;
  logic                  res_ok;
  logic [PW+PROC_W-1:0]  pi_w;
  logic [RW+RES_W-1:0]   ri_w;
  logic [NW-1:0]         need_wr;
  logic signed [NW-1:0]  need_rd;
  logic [COUNT_WIDTH-1:0] alloc_rd;
  logic                  need_ok;
  logic                  fit_now;
  logic signed [NW-1:0]  need0_eff;
  logic                  better;
  logic                  scan_issue;
  logic                  add_issue;
  logic [PW+PROC_W-1:0]  pick_w;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // Effective counts, clamped to the sizes built.
  always_comb begin
    if (32'(process_count) > MAX_PROCESSES) begin
      np = PCW'(MAX_PROCESSES);
    end else begin
      np = PCW'(process_count);
    end
    if (32'(resource_count) > MAX_RESOURCES) begin
      nr = RCW'(MAX_RESOURCES);
    end else begin
      nr = RCW'(resource_count);
    end
    if (nr == '0) begin
      nr_last = '0;
    end else begin
      nr_last = RW'(nr - RCW'(1));
    end
  end

  assign ip_idx = ip[PW-1:0];

  // Load decode and table write.
  assign proc_ok   = 32'(proc_index) < MAX_PROCESSES;
  assign res_ok    = 32'(res_index) < MAX_RESOURCES;
  assign pi_w      = (PW + PROC_W)'(proc_index);
  assign ri_w      = (RW + RES_W)'(res_index);
  assign need_wr   = {1'b0, max_value} - {1'b0, alloc_value};
  assign mem_we    = in_acc && (req_type == REQ_LOAD_PROC) && proc_ok && res_ok;
  assign mem_waddr = {pi_w[PW-1:0], ri_w[RW-1:0]};
  assign mem_wdata = {need_wr, alloc_value};

  // Read address: the fit scan walks (process, resource); the add walks the pick's row.
  assign scan_issue = (state == ST_SCAN) && (ip < np) && !finished[ip_idx];
  assign add_issue  = (state == ST_ADD);
  assign mem_re     = scan_issue || add_issue;
  assign mem_raddr  = add_issue ? {pick, ir} : {ip_idx, ir};

  bsc_table_mem #(
    .DATA_W (MEM_W),
    .ADDR_W (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign need_rd  = mem_rdata[MEM_W-1:COUNT_WIDTH];
  assign alloc_rd = mem_rdata[COUNT_WIDTH-1:0];

  // Fit test of the entry just read and the running minimum of need 0.
  always_comb begin
    need_ok = (nr == '0) ||
              !(!need_rd[NW-1] && (|need_rd[NW-2:0]) &&
                (WW'(need_rd[NW-2:0]) > work[s_r]));
    fit_now   = need_ok && (s_first || fit_acc);
    need0_eff = s_first ? need_rd : need0;
    better    = !found || ((nr != '0) && (need0_eff < best_need));
  end

  assign pick_w = (PW + PROC_W)'(pick);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= PCNT_W'(1);
      resource_count <= RCNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROCESS_COUNT:  process_count  <= cfg_data[PCNT_W-1:0];
        CFG_RESOURCE_COUNT: resource_count <= cfg_data[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Available counts.
  always_ff @(posedge clk) begin
    if (in_acc && (req_type == REQ_LOAD_AVAIL) && res_ok) begin
      avail[ri_w[RW-1:0]] <= avail_value;
    end
  end

  // Work counts: loaded at the start of a run, then grown by each pick's row.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_RESOURCES; r++) begin
        work[r] <= '0;
      end
    end else if (in_acc && (req_type == REQ_RUN)) begin
      for (int r = 0; r < MAX_RESOURCES; r++) begin
        work[r] <= WW'(avail[r]);
      end
    end else if (av) begin
      work[a_r] <= work[a_r] + WW'(alloc_rd);
    end
  end

  // Run sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      finished    <= '0;
      ip          <= '0;
      ir          <= '0;
      done_count  <= '0;
      found       <= 1'b0;
      sv          <= 1'b0;
      av          <= 1'b0;
      out_valid   <= 1'b0;
      pick        <= '0;
      best_need   <= '0;
      need0       <= '0;
      fit_acc     <= 1'b0;
      s_p         <= '0;
      s_r         <= '0;
      s_first     <= 1'b0;
      s_last      <= 1'b0;
      a_r         <= '0;
      seq_process <= '0;
      is_verdict  <= 1'b0;
      safe        <= 1'b0;
      last        <= 1'b0;
    end else begin
      // A read issued this cycle has its data next cycle.
      sv <= scan_issue;
      av <= add_issue;
      if (out_valid && !out_stall && (state != ST_DECIDE)) begin
        out_valid <= 1'b0;
      end

      // Data stage of the fit scan.
      if (sv) begin
        fit_acc <= fit_now;
        if (s_first) begin
          need0 <= need_rd;
        end
        if (s_last && fit_now && better) begin
          found     <= 1'b1;
          pick      <= s_p;
          best_need <= need0_eff;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc && (req_type == REQ_RUN)) begin
            finished   <= '0;
            done_count <= '0;
            ip         <= '0;
            ir         <= '0;
            found      <= 1'b0;
            state      <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (ip < np) begin
            if (finished[ip_idx]) begin
              ip <= ip + PCW'(1);
            end else begin
              s_p     <= ip_idx;
              s_r     <= ir;
              s_first <= (ir == '0);
              s_last  <= (ir == nr_last);
              if (ir == nr_last) begin
                ir <= '0;
                ip <= ip + PCW'(1);
              end else begin
                ir <= ir + RW'(1);
              end
            end
          end else if (!sv) begin
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (found) begin
              seq_process    <= pick_w[PROC_W-1:0];
              is_verdict     <= 1'b0;
              safe           <= 1'b0;
              last           <= 1'b0;
              finished[pick] <= 1'b1;
              done_count     <= done_count + PCW'(1);
              ir             <= '0;
              if (nr == '0) begin
                ip    <= '0;
                found <= 1'b0;
                state <= ST_SCAN;
              end else begin
                state <= ST_ADD;
              end
            end else begin
              seq_process <= '0;
              is_verdict  <= 1'b1;
              safe        <= (done_count == np);
              last        <= 1'b1;
              state       <= ST_IDLE;
            end
          end
        end

        ST_ADD: begin
          a_r <= ir;
          if (ir == nr_last) begin
            ir    <= '0;
            state <= ST_ADD_DRAIN;
          end else begin
            ir <= ir + RW'(1);
          end
        end

        ST_ADD_DRAIN: begin
          ip    <= '0;
          ir    <= '0;
          found <= 1'b0;
          state <= ST_SCAN;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
